// ----- rtl/dts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and register indexes of the delimited token splitter.
package dts_pkg;

	localparam int BYTE_W          = 8;
	localparam int CFG_INDEX_W     = 4;
	localparam int CFG_DATA_W      = 64;
	localparam int SEP_COUNT_W     = 4;
	localparam int DELIM_COUNT_W   = 3;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_SEPARATORS  = 8;
	localparam int DEF_MAX_DELIM_PAIRS = 4;

	// Depths of the queue between front and back and of the result queue.
	localparam int MID_QUEUE_DEPTH = 4;
	localparam int OUT_QUEUE_DEPTH = 2;

	// Reset values of the double-byte lead range.
	localparam logic [BYTE_W-1:0] LEAD_LOW_RESET  = 8'd129;
	localparam logic [BYTE_W-1:0] LEAD_HIGH_RESET = 8'd254;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SEP_CHARS    = 4'd0,
		CFG_SEP_COUNT    = 4'd1,
		CFG_DELIM_OPENS  = 4'd2,
		CFG_DELIM_CLOSES = 4'd3,
		CFG_DELIM_KEEP   = 4'd4,
		CFG_DELIM_COUNT  = 4'd5,
		CFG_LEAD_LOW     = 4'd6,
		CFG_LEAD_HIGH    = 4'd7
	} dts_cfg_reg_t;

	// One input byte after classification by the front.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
		logic              is_sep;
		logic              is_lead;
		logic              delim_hit;
		logic [BYTE_W-1:0] close_byte;
		logic              keep;
	} dts_item_t;

	// One result word.
	typedef struct packed {
		logic              byte_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              token_end;
		logic              strip_ends;
		logic              string_done;
	} dts_result_t;

	// All results caused by one input byte: one or two words.
	typedef struct packed {
		logic        two;
		dts_result_t r1;
		dts_result_t r0;
	} dts_pair_t;

endpackage

// ----- rtl/delimited_token_splitter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the delimited token splitter.
//
// Splits a byte string into tokens, one byte per input word, with quoted
// (delimited) tokens and double-byte characters. The block takes one input
// word every clock cycle while full is low: the front classifies the byte
// against the separator, lead and delimiter registers in the cycle it is
// accepted and writes it into a four-entry queue; the back takes one queued
// byte per cycle while the result queue is not full, updates the token
// state and writes its one or two result words into a two-entry result
// queue. A byte's first result word reaches the result ports after it has
// been registered in the queue between front and back and then in the
// result queue. A byte that causes no result word, such as a separator
// outside a token, uses no result queue entry. Most bytes give one result
// word; a separator after a delimited token's closing byte gives two only if
// it is also a lead byte, and those take two pops, so the sustained rate is
// one result word per cycle, limited only by the result port. Configuration
// writes are always ready and must be made while the block is idle.
module delimited_token_splitter_unit #(
	parameter int MAX_SEPARATORS  = dts_pkg::DEF_MAX_SEPARATORS,
	parameter int MAX_DELIM_PAIRS = dts_pkg::DEF_MAX_DELIM_PAIRS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [dts_pkg::BYTE_W-1:0]       in_byte,
	input  logic                             last_byte,
	input  logic                             pop,
	output logic                             empty,
	output logic                             byte_valid,
	output logic [dts_pkg::BYTE_W-1:0]       out_byte,
	output logic                             token_end,
	output logic                             strip_ends,
	output logic                             string_done,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dts_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dts_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import dts_pkg::*;

	localparam int ITEM_W = $bits(dts_item_t);

	dts_item_t         front_item;
	logic [ITEM_W-1:0] mid_rd;
	dts_item_t         back_item;
	logic              mid_empty;
	logic              back_take;
	dts_result_t       result;

	// Classification and configuration registers.
	dts_front #(
		.MAX_SEPARATORS (MAX_SEPARATORS),
		.MAX_DELIM_PAIRS(MAX_DELIM_PAIRS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (in_byte),
		.last_byte(last_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (front_item)
	);

	// Queue between front and back.
	dts_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(MID_QUEUE_DEPTH)
	) u_mid_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(front_item),
		.full   (full),
		.pop    (back_take),
		.rd_data(mid_rd),
		.empty  (mid_empty)
	);

	assign back_item = dts_item_t'(mid_rd);

	// Token state machine and result queue.
	dts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (back_item),
		.item_avail(~mid_empty),
		.item_take (back_take),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

	assign byte_valid  = result.byte_valid;
	assign out_byte    = result.out_byte;
	assign token_end   = result.token_end;
	assign strip_ends  = result.strip_ends;
	assign string_done = result.string_done;

endmodule

// ----- rtl/dts_queue.sv -----
`timescale 1ns / 1ps
// Small first-in first-out queue built from registers.
module dts_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push & ~full;
	assign pop_ok  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage words carry no reset.
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/dts_front.sv -----
`timescale 1ns / 1ps
// Front end: configuration registers and per-byte classification.
module dts_front #(
	parameter int MAX_SEPARATORS  = 8,
	parameter int MAX_DELIM_PAIRS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [dts_pkg::BYTE_W-1:0]       in_byte,
	input  logic                             last_byte,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dts_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dts_pkg::CFG_DATA_W-1:0]   cfg_data,
	output dts_pkg::dts_item_t               item
);

	import dts_pkg::*;

	localparam int SEP_BITS   = MAX_SEPARATORS * BYTE_W;
	localparam int DELIM_BITS = MAX_DELIM_PAIRS * BYTE_W;

	logic [SEP_BITS-1:0]      sep_chars_q;
	logic [SEP_COUNT_W-1:0]   sep_count_q;
	logic [DELIM_BITS-1:0]    delim_opens_q;
	logic [DELIM_BITS-1:0]    delim_closes_q;
	logic [MAX_DELIM_PAIRS-1:0] delim_keep_q;
	logic [DELIM_COUNT_W-1:0] delim_count_q;
	logic [BYTE_W-1:0]        lead_low_q;
	logic [BYTE_W-1:0]        lead_high_q;
	logic                     cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_chars_q    <= '0;
			sep_count_q    <= '0;
			delim_opens_q  <= '0;
			delim_closes_q <= '0;
			delim_keep_q   <= '0;
			delim_count_q  <= '0;
			lead_low_q     <= LEAD_LOW_RESET;
			lead_high_q    <= LEAD_HIGH_RESET;
		end else if (cfg_wr) begin
			unique case (dts_cfg_reg_t'(cfg_index))
				CFG_SEP_CHARS:    sep_chars_q    <= cfg_data[SEP_BITS-1:0];
				CFG_SEP_COUNT:    sep_count_q    <= cfg_data[SEP_COUNT_W-1:0];
				CFG_DELIM_OPENS:  delim_opens_q  <= cfg_data[DELIM_BITS-1:0];
				CFG_DELIM_CLOSES: delim_closes_q <= cfg_data[DELIM_BITS-1:0];
				CFG_DELIM_KEEP:   delim_keep_q   <= cfg_data[MAX_DELIM_PAIRS-1:0];
				CFG_DELIM_COUNT:  delim_count_q  <= cfg_data[DELIM_COUNT_W-1:0];
				CFG_LEAD_LOW:     lead_low_q     <= cfg_data[BYTE_W-1:0];
				CFG_LEAD_HIGH:    lead_high_q    <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Classification: separator, lead byte and the lowest matching opening delimiter.
	always_comb begin
		item            = '0;
		item.data       = in_byte;
		item.last       = last_byte;
		item.is_lead    = (in_byte >= lead_low_q) && (in_byte <= lead_high_q);
		for (int k = 0; k < MAX_SEPARATORS; k++) begin
			if ((SEP_COUNT_W'(k) < sep_count_q) &&
			    (sep_chars_q[k*BYTE_W +: BYTE_W] == in_byte)) begin
				item.is_sep = 1'b1;
			end
		end
		if (in_byte == '0) begin
			item.is_sep = 1'b0;
		end
		// Scan downwards so that the lowest pair wins.
		for (int p = MAX_DELIM_PAIRS - 1; p >= 0; p--) begin
			if ((DELIM_COUNT_W'(p) < delim_count_q) &&
			    (delim_opens_q[p*BYTE_W +: BYTE_W] == in_byte)) begin
				item.delim_hit  = 1'b1;
				item.close_byte = delim_closes_q[p*BYTE_W +: BYTE_W];
				item.keep       = delim_keep_q[p];
			end
		end
	end

endmodule

// ----- rtl/dts_back.sv -----
`timescale 1ns / 1ps
// Back end: token state, result words and the result queue.
module dts_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dts_pkg::dts_item_t   item,
	input  logic                 item_avail,
	output logic                 item_take,
	input  logic                 pop,
	output logic                 empty,
	output dts_pkg::dts_result_t result
);

	import dts_pkg::*;

	localparam int PAIR_W = $bits(dts_pair_t);

	logic              token_open_q;
	logic              in_delim_q;
	logic [BYTE_W-1:0] close_byte_q;
	logic              keep_ends_q;
	logic              close_pending_q;
	logic              expect_trail_q;
	logic              sel_q;

	logic              token_open_d;
	logic              in_delim_d;
	logic [BYTE_W-1:0] close_byte_d;
	logic              keep_ends_d;
	logic              close_pending_d;
	logic              expect_trail_d;

	logic              close_sep;
	logic              open_now;
	logic              delim_now;
	logic              mid_v;
	dts_result_t       mid;
	dts_result_t       pre;
	dts_pair_t         pair;

	logic              oq_full;
	logic              oq_empty;
	logic              oq_push;
	logic              oq_pop;
	logic [PAIR_W-1:0] oq_rd;
	dts_pair_t         head;
	logic              pop_ok;

	assign item_take = item_avail & ~oq_full;

	// Next state and the results of one byte.
	always_comb begin
		close_sep       = close_pending_q & item.is_sep;
		open_now        = token_open_q & ~close_sep;
		delim_now       = in_delim_q & ~close_sep;
		token_open_d    = open_now;
		in_delim_d      = delim_now;
		close_byte_d    = close_byte_q;
		keep_ends_d     = keep_ends_q;
		close_pending_d = 1'b0;
		expect_trail_d  = 1'b0;
		mid_v           = 1'b0;
		mid             = '0;
		pre             = '0;
		pair            = '0;

		// A pending close met by a separator ends the token with no byte.
		pre.token_end  = 1'b1;
		pre.strip_ends = ~keep_ends_q;

		if (expect_trail_q) begin
			mid_v          = 1'b1;
			mid.byte_valid = 1'b1;
			mid.out_byte   = item.data;
			token_open_d   = 1'b1;
		end else if (item.is_lead) begin
			mid_v          = 1'b1;
			mid.byte_valid = 1'b1;
			mid.out_byte   = item.data;
			token_open_d   = 1'b1;
			expect_trail_d = 1'b1;
		end else if (delim_now) begin
			mid_v          = 1'b1;
			mid.byte_valid = 1'b1;
			mid.out_byte   = item.data;
			token_open_d   = 1'b1;
			if (item.data == close_byte_q) begin
				if (item.last) begin
					mid.token_end  = 1'b1;
					mid.strip_ends = ~keep_ends_q;
					token_open_d   = 1'b0;
					in_delim_d     = 1'b0;
				end else begin
					close_pending_d = 1'b1;
				end
			end
		end else if (item.is_sep) begin
			if (open_now) begin
				mid_v         = 1'b1;
				mid.token_end = 1'b1;
				token_open_d  = 1'b0;
				in_delim_d    = 1'b0;
			end
		end else begin
			mid_v          = 1'b1;
			mid.byte_valid = 1'b1;
			mid.out_byte   = item.data;
			if (!open_now && item.delim_hit) begin
				in_delim_d   = 1'b1;
				close_byte_d = item.close_byte;
				keep_ends_d  = item.keep;
			end
			token_open_d = 1'b1;
		end

		// End of string closes a token that is still open after this byte.
		if (item.last && token_open_d) begin
			mid.token_end  = 1'b1;
			mid.strip_ends = 1'b0;
		end

		if (close_sep) begin
			pair.r0 = pre;
			if (mid_v) begin
				pair.r1  = mid;
				pair.two = 1'b1;
			end
		end else if (mid_v) begin
			pair.r0 = mid;
		end

		if (item.last) begin
			if (pair.two) begin
				pair.r1.string_done = 1'b1;
			end else begin
				pair.r0.string_done = 1'b1;
			end
			token_open_d    = 1'b0;
			in_delim_d      = 1'b0;
			close_byte_d    = '0;
			keep_ends_d     = 1'b0;
			close_pending_d = 1'b0;
			expect_trail_d  = 1'b0;
		end
	end

	// Token state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_open_q    <= 1'b0;
			in_delim_q      <= 1'b0;
			close_byte_q    <= '0;
			keep_ends_q     <= 1'b0;
			close_pending_q <= 1'b0;
			expect_trail_q  <= 1'b0;
		end else if (item_take) begin
			token_open_q    <= token_open_d;
			in_delim_q      <= in_delim_d;
			close_byte_q    <= close_byte_d;
			keep_ends_q     <= keep_ends_d;
			close_pending_q <= close_pending_d;
			expect_trail_q  <= expect_trail_d;
		end
	end

	// A byte that causes no result word leaves the result queue untouched.
	assign oq_push = item_take & (close_sep | mid_v | item.last);

	// Result queue holds the results of one byte per entry.
	dts_queue #(
		.WIDTH(PAIR_W),
		.DEPTH(OUT_QUEUE_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wr_data(pair),
		.full   (oq_full),
		.pop    (oq_pop),
		.rd_data(oq_rd),
		.empty  (oq_empty)
	);

	assign head   = dts_pair_t'(oq_rd);
	assign empty  = oq_empty;
	assign pop_ok = pop & ~oq_empty;
	assign oq_pop = pop_ok & (~head.two | sel_q);
	assign result = sel_q ? head.r1 : head.r0;

	// Selects the second word of an entry that carries two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (pop_ok) begin
			sel_q <= head.two & ~sel_q;
		end
	end

	a_pending_in_delim: assert property (@(posedge clk) disable iff (!arst_n)
		close_pending_q |-> in_delim_q)
		else $error("close pending outside a delimited token");

	a_trail_open: assert property (@(posedge clk) disable iff (!arst_n)
		expect_trail_q |-> token_open_q)
		else $error("trail byte expected with no open token");

	a_delim_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_delim_q |-> token_open_q)
		else $error("delimited token without an open token");

	a_sel_head: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (!oq_empty && head.two))
		else $error("second word selected on an entry without one");

endmodule
